/* design/amr_storage_frame_parser_assert.svh */
// assertion macros for the amr storage frame parser
// expects aclk and aresetn in the scope of the module that uses them
`ifndef AMR_STORAGE_FRAME_PARSER_ASSERT_SVH
`define AMR_STORAGE_FRAME_PARSER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AMRSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AMRSP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/amrsp_pkg.sv */
// shared types, constants and tables for the amr storage frame parser
// no dependencies
package amrsp_pkg;

    localparam int TYPE_W      = 4;
    localparam int BLEFT_W     = 6;
    localparam int FNUM_W      = 24;
    localparam int TIME_W      = 39;
    localparam int OFFSET_W    = 32;
    localparam int MAGIC_POS_W = 4;
    localparam int STATUS_W    = 3;
    localparam int PBITS_W     = 10;

    localparam int INDEX_TABLE_ENTRIES_DEF = 64;
    localparam int INDEX_SPACING_DEF       = 50;

    localparam logic [7:0]          PAD_MASK    = 8'h83;
    localparam logic [TIME_W-1:0]   FRAME_US    = TIME_W'(20000);
    localparam logic [FNUM_W-1:0]   COUNT_MAX   = '1;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX  = '1;
    localparam logic [MAGIC_POS_W-1:0] NB_LAST_POS = MAGIC_POS_W'(5);
    localparam logic [MAGIC_POS_W-1:0] WB_LAST_POS = MAGIC_POS_W'(8);
    localparam logic [MAGIC_POS_W-1:0] MAGIC_LEN   = MAGIC_POS_W'(9);
    localparam logic [7:0]          CHAR_LF     = 8'h0a;

    typedef enum logic [3:0] {
        PH_MAGIC   = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_HALT    = 4'b1000
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_MAGIC = 3'd1,
        ST_BAD_TYPE  = 3'd2,
        ST_PAD_SET   = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_HALTED    = 3'd5
    } parse_status_t;

    typedef struct packed {
        logic               pad_bad;
        logic               type_bad;
        logic [TYPE_W-1:0]  ftype;
        logic [BLEFT_W-1:0] nbytes;
    } hdr_info_t;

    // wideband magic line; narrowband shares the first five characters
    function automatic logic [7:0] magic_char(input logic [MAGIC_POS_W-1:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = 8'h23;
            4'd1:    c = 8'h21;
            4'd2:    c = 8'h41;
            4'd3:    c = 8'h4d;
            4'd4:    c = 8'h52;
            4'd5:    c = 8'h2d;
            4'd6:    c = 8'h57;
            4'd7:    c = 8'h42;
            4'd8:    c = 8'h0a;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // payload bit count per frame type
    function automatic logic [PBITS_W-1:0] payload_bits(input logic wide,
                                                        input logic [TYPE_W-1:0] ft);
        logic [PBITS_W-1:0] n;
        if (wide) begin
            case (ft)
                4'd0:    n = 10'd132;
                4'd1:    n = 10'd177;
                4'd2:    n = 10'd253;
                4'd3:    n = 10'd285;
                4'd4:    n = 10'd317;
                4'd5:    n = 10'd365;
                4'd6:    n = 10'd397;
                4'd7:    n = 10'd461;
                4'd8:    n = 10'd477;
                4'd9:    n = 10'd40;
                default: n = 10'd0;
            endcase
        end else begin
            case (ft)
                4'd0:    n = 10'd95;
                4'd1:    n = 10'd103;
                4'd2:    n = 10'd118;
                4'd3:    n = 10'd134;
                4'd4:    n = 10'd148;
                4'd5:    n = 10'd159;
                4'd6:    n = 10'd204;
                4'd7:    n = 10'd244;
                4'd8:    n = 10'd39;
                4'd9:    n = 10'd43;
                4'd10:   n = 10'd38;
                4'd11:   n = 10'd37;
                default: n = 10'd0;
            endcase
        end
        return n;
    endfunction

endpackage

/* design/amr_storage_frame_parser.sv */
// Frame parser for AMR storage files. Takes one file byte per transfer on the s_ side and
// returns the same byte with its frame marks on the m_ side, one result per byte. Throughput is
// one byte per clock while m_tready keeps up; each byte goes through the input register and then
// the result register, with the whole per-byte step (magic match, header decode, counter
// updates) done in the logic between them. A result waiting on m_tready lets a byte into an
// empty input register but not into a full one. Errors stop the parser until reset; a clean
// end of stream returns it to the magic-line state. No clearing pass is needed after reset.
// depends on amrsp_pkg, amrsp_hdr_decode and amr_storage_frame_parser_assert.svh
`include "amr_storage_frame_parser_assert.svh"

module amr_storage_frame_parser #(
    parameter int INDEX_TABLE_ENTRIES = amrsp_pkg::INDEX_TABLE_ENTRIES_DEF,
    parameter int INDEX_SPACING       = amrsp_pkg::INDEX_SPACING_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,   // check_padding
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,       // byte_in
    input  logic         s_tlast,       // end_of_stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // byte_out, frame_start, frame_type, wide_stream, frame_number, frame_time_us,
    // frame_offset, index_point, status, zero fill
    output logic [119:0] m_tdata,
    output logic         m_tlast,       // frame_end
    output logic         m_tuser        // in_frame
);

    localparam int MOD_W  = (INDEX_SPACING > 1) ? $clog2(INDEX_SPACING) : 1;
    localparam int QUOT_W = $clog2(INDEX_TABLE_ENTRIES + 1);

    localparam int TYPE_W   = amrsp_pkg::TYPE_W;
    localparam int BLEFT_W  = amrsp_pkg::BLEFT_W;
    localparam int FNUM_W   = amrsp_pkg::FNUM_W;
    localparam int TIME_W   = amrsp_pkg::TIME_W;
    localparam int OFFSET_W = amrsp_pkg::OFFSET_W;
    localparam int POS_W    = amrsp_pkg::MAGIC_POS_W;

    // configuration
    logic check_padding_reg;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    // parser state
    amrsp_pkg::phase_t    phase_reg, phase_next;
    logic [POS_W-1:0]     magic_pos_reg, magic_pos_next;
    logic                 wide_reg, wide_next;
    logic [BLEFT_W-1:0]   bytes_left_reg, bytes_left_next;
    logic [TYPE_W-1:0]    cur_type_reg, cur_type_next;
    logic [FNUM_W-1:0]    frame_count_reg, frame_count_next;
    logic [TIME_W-1:0]    time_now_reg, time_now_next;
    logic [OFFSET_W-1:0]  byte_off_reg, byte_off_next;
    logic [OFFSET_W-1:0]  hdr_off_reg, hdr_off_next;
    logic [MOD_W-1:0]     idx_mod_reg, idx_mod_next;
    logic [QUOT_W-1:0]    idx_quot_reg, idx_quot_next;

    // result register
    logic                 m_valid_reg, m_valid_next;
    logic [7:0]           r_byte_reg, r_byte_next;
    logic                 r_in_frame_reg, r_in_frame_next;
    logic                 r_start_reg, r_start_next;
    logic                 r_end_reg, r_end_next;
    logic [TYPE_W-1:0]    r_type_reg, r_type_next;
    logic                 r_wide_reg, r_wide_next;
    logic [FNUM_W-1:0]    r_num_reg, r_num_next;
    logic [TIME_W-1:0]    r_time_reg, r_time_next;
    logic [OFFSET_W-1:0]  r_off_reg, r_off_next;
    logic                 r_index_reg, r_index_next;
    amrsp_pkg::parse_status_t r_status_reg, r_status_next;

    logic                 advance;
    logic                 accept_in;
    amrsp_pkg::hdr_info_t hdr;

    assign advance   = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign accept_in = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept_in) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    amrsp_hdr_decode u_hdr_decode (
        .check_padding (check_padding_reg),
        .wide          (wide_reg),
        .hdr_byte      (in_byte_reg),
        .info          (hdr)
    );

    // per-byte parser step
    always_comb begin
        logic done;
        logic bad;
        logic err;
        logic clean_end;

        done      = 1'b0;
        bad       = 1'b0;
        err       = 1'b0;
        clean_end = 1'b0;

        phase_next       = phase_reg;
        magic_pos_next   = magic_pos_reg;
        wide_next        = wide_reg;
        bytes_left_next  = bytes_left_reg;
        cur_type_next    = cur_type_reg;
        frame_count_next = frame_count_reg;
        time_now_next    = time_now_reg;
        byte_off_next    = byte_off_reg;
        hdr_off_next     = hdr_off_reg;
        idx_mod_next     = idx_mod_reg;
        idx_quot_next    = idx_quot_reg;

        r_byte_next     = in_byte_reg;
        r_in_frame_next = 1'b0;
        r_start_next    = 1'b0;
        r_end_next      = 1'b0;
        r_type_next     = '0;
        r_num_next      = '0;
        r_time_next     = '0;
        r_off_next      = '0;
        r_index_next    = 1'b0;
        r_status_next   = amrsp_pkg::ST_OK;

        unique case (phase_reg)
            amrsp_pkg::PH_HALT: begin
                r_status_next = amrsp_pkg::ST_HALTED;
            end
            amrsp_pkg::PH_MAGIC: begin
                if (magic_pos_reg == amrsp_pkg::NB_LAST_POS && in_byte_reg == amrsp_pkg::CHAR_LF) begin
                    wide_next = 1'b0;
                    done      = 1'b1;
                end else if (magic_pos_reg < amrsp_pkg::MAGIC_LEN
                             && in_byte_reg == amrsp_pkg::magic_char(magic_pos_reg)) begin
                    if (magic_pos_reg == amrsp_pkg::WB_LAST_POS) begin
                        wide_next = 1'b1;
                        done      = 1'b1;
                    end else begin
                        magic_pos_next = magic_pos_reg + POS_W'(1);
                    end
                end else begin
                    bad = 1'b1;
                end
                if (bad || (in_eos_reg && !done)) begin
                    phase_next    = amrsp_pkg::PH_HALT;
                    r_status_next = amrsp_pkg::ST_BAD_MAGIC;
                end else if (done) begin
                    magic_pos_next = '0;
                    phase_next     = amrsp_pkg::PH_HEADER;
                    clean_end      = in_eos_reg;
                end
            end
            amrsp_pkg::PH_HEADER: begin
                if (hdr.pad_bad) begin
                    err           = 1'b1;
                    r_status_next = amrsp_pkg::ST_PAD_SET;
                end else if (hdr.type_bad) begin
                    err           = 1'b1;
                    r_status_next = amrsp_pkg::ST_BAD_TYPE;
                end else begin
                    cur_type_next   = hdr.ftype;
                    hdr_off_next    = byte_off_reg;
                    bytes_left_next = hdr.nbytes;
                    r_start_next    = 1'b1;
                    r_index_next    = (idx_mod_reg == MOD_W'(0))
                                      && (idx_quot_reg < QUOT_W'(INDEX_TABLE_ENTRIES));
                    if (hdr.nbytes == '0) begin
                        r_end_next = 1'b1;
                    end else if (in_eos_reg) begin
                        err           = 1'b1;
                        r_status_next = amrsp_pkg::ST_TRUNCATED;
                    end else begin
                        phase_next = amrsp_pkg::PH_PAYLOAD;
                    end
                end
            end
            amrsp_pkg::PH_PAYLOAD: begin
                if (bytes_left_reg <= BLEFT_W'(1)) begin
                    bytes_left_next = '0;
                    r_end_next      = 1'b1;
                end else if (in_eos_reg) begin
                    err           = 1'b1;
                    r_status_next = amrsp_pkg::ST_TRUNCATED;
                end else begin
                    bytes_left_next = bytes_left_reg - BLEFT_W'(1);
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase

        if (phase_reg == amrsp_pkg::PH_HEADER || phase_reg == amrsp_pkg::PH_PAYLOAD) begin
            if (err) begin
                phase_next   = amrsp_pkg::PH_HALT;
                r_start_next = 1'b0;
                r_end_next   = 1'b0;
                r_index_next = 1'b0;
            end else begin
                r_in_frame_next = 1'b1;
                r_type_next     = cur_type_next;
                r_num_next      = frame_count_reg;
                r_time_next     = time_now_reg;
                r_off_next      = hdr_off_next;
                if (byte_off_reg != amrsp_pkg::OFFSET_MAX) begin
                    byte_off_next = byte_off_reg + OFFSET_W'(1);
                end
                if (r_end_next) begin
                    phase_next = amrsp_pkg::PH_HEADER;
                    // counters stop together once the frame count saturates
                    if (frame_count_reg != amrsp_pkg::COUNT_MAX) begin
                        frame_count_next = frame_count_reg + FNUM_W'(1);
                        time_now_next    = time_now_reg + amrsp_pkg::FRAME_US;
                        if (idx_mod_reg == MOD_W'(INDEX_SPACING - 1)) begin
                            idx_mod_next = '0;
                            if (idx_quot_reg != QUOT_W'(INDEX_TABLE_ENTRIES)) begin
                                idx_quot_next = idx_quot_reg + QUOT_W'(1);
                            end
                        end else begin
                            idx_mod_next = idx_mod_reg + MOD_W'(1);
                        end
                    end
                end
                clean_end = in_eos_reg;
            end
        end

        r_wide_next = wide_next;

        // clean end of file: back to the magic line for the next file
        if (clean_end) begin
            phase_next       = amrsp_pkg::PH_MAGIC;
            magic_pos_next   = '0;
            wide_next        = 1'b0;
            bytes_left_next  = '0;
            cur_type_next    = '0;
            frame_count_next = '0;
            time_now_next    = '0;
            byte_off_next    = '0;
            hdr_off_next     = '0;
            idx_mod_next     = '0;
            idx_quot_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_padding_reg <= 1'b1;
            in_valid_reg      <= 1'b0;
            m_valid_reg       <= 1'b0;
            phase_reg         <= amrsp_pkg::PH_MAGIC;
            magic_pos_reg     <= '0;
            wide_reg          <= 1'b0;
            bytes_left_reg    <= '0;
            cur_type_reg      <= '0;
            frame_count_reg   <= '0;
            time_now_reg      <= '0;
            byte_off_reg      <= '0;
            hdr_off_reg       <= '0;
            idx_mod_reg       <= '0;
            idx_quot_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                check_padding_reg <= cfg_wr_data;
            end
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                phase_reg       <= phase_next;
                magic_pos_reg   <= magic_pos_next;
                wide_reg        <= wide_next;
                bytes_left_reg  <= bytes_left_next;
                cur_type_reg    <= cur_type_next;
                frame_count_reg <= frame_count_next;
                time_now_reg    <= time_now_next;
                byte_off_reg    <= byte_off_next;
                hdr_off_reg     <= hdr_off_next;
                idx_mod_reg     <= idx_mod_next;
                idx_quot_reg    <= idx_quot_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
        if (advance) begin
            r_byte_reg     <= r_byte_next;
            r_in_frame_reg <= r_in_frame_next;
            r_start_reg    <= r_start_next;
            r_end_reg      <= r_end_next;
            r_type_reg     <= r_type_next;
            r_wide_reg     <= r_wide_next;
            r_num_reg      <= r_num_next;
            r_time_reg     <= r_time_next;
            r_off_reg      <= r_off_next;
            r_index_reg    <= r_index_next;
            r_status_reg   <= r_status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = r_end_reg;
    assign m_tuser  = r_in_frame_reg;
    assign m_tdata  = {7'b0, r_status_reg, r_index_reg, r_off_reg, r_time_reg, r_num_reg,
                       r_wide_reg, r_type_reg, r_start_reg, r_byte_reg};

    `AMRSP_ASSERT_IMP(a_payload_has_bytes, phase_reg == amrsp_pkg::PH_PAYLOAD, bytes_left_reg != '0, "payload phase with no bytes left")
    `AMRSP_ASSERT_IMP(a_header_no_bytes, phase_reg == amrsp_pkg::PH_HEADER, bytes_left_reg == '0, "header phase with bytes still owed")
    `AMRSP_ASSERT_IMP(a_index_on_start, m_valid_reg && r_index_reg, r_start_reg, "index point off a frame header")
    `AMRSP_ASSERT_IMP(a_start_clean, m_valid_reg && r_start_reg, r_in_frame_reg && r_status_reg == amrsp_pkg::ST_OK, "frame start with error or outside frame")
    `AMRSP_ASSERT_NXT(a_halt_reports, phase_reg == amrsp_pkg::PH_HALT && advance, m_valid_reg && r_status_reg == amrsp_pkg::ST_HALTED, "halted parser did not report halt")

endmodule

/* design/amrsp_hdr_decode.sv */
// frame header byte decoder: padding check, type legality, payload length in bytes
// depends on amrsp_pkg
module amrsp_hdr_decode (
    input  logic                 check_padding,
    input  logic                 wide,
    input  logic [7:0]           hdr_byte,
    output amrsp_pkg::hdr_info_t info
);

    logic [amrsp_pkg::TYPE_W-1:0]  ft;
    logic [amrsp_pkg::PBITS_W-1:0] nbits;
    logic [amrsp_pkg::PBITS_W-1:0] rounded;

    assign ft      = hdr_byte[6:3];
    assign nbits   = amrsp_pkg::payload_bits(wide, ft);
    assign rounded = nbits + amrsp_pkg::PBITS_W'(7);

    always_comb begin
        info.pad_bad = check_padding && ((hdr_byte & amrsp_pkg::PAD_MASK) != 8'h00);
        // reserved types: 10..13 wideband, 12..14 narrowband
        if (wide) begin
            info.type_bad = (ft >= 4'd10) && (ft <= 4'd13);
        end else begin
            info.type_bad = (ft >= 4'd12) && (ft <= 4'd14);
        end
        info.ftype  = ft;
        // longest payload rounds to 60 bytes, so six bits are enough
        info.nbytes = rounded[amrsp_pkg::BLEFT_W+2:3];
    end

endmodule

/* bench/amr_storage_frame_parser_test.sv */
// self-checking bench for amr_storage_frame_parser: byte streams in, per-byte frame marks out
// depends on amrsp_pkg and the parser rtl; results are predicted in the bench and compared
`timescale 1ns / 100ps

module amr_storage_frame_parser_test;

    localparam int unsigned IDX_ENTRIES = amrsp_pkg::INDEX_TABLE_ENTRIES_DEF;
    localparam int unsigned IDX_SPACING = amrsp_pkg::INDEX_SPACING_DEF;
    localparam int unsigned IDLE_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_BYTES = 800;

    localparam int unsigned NB_PAYLOAD_BITS [16] =
        '{95, 103, 118, 134, 148, 159, 204, 244, 39, 43, 38, 37, 0, 0, 0, 0};
    localparam int unsigned WB_PAYLOAD_BITS [16] =
        '{132, 177, 253, 285, 317, 365, 397, 461, 477, 40, 0, 0, 0, 0, 0, 0};
    localparam logic [7:0] WB_MAGIC [9] =
        '{8'h23, 8'h21, 8'h41, 8'h4d, 8'h52, 8'h2d, 8'h57, 8'h42, 8'h0a};

    typedef enum int {
        FAIL_MAGIC_BYTE,
        FAIL_MAGIC_CUT,
        FAIL_PADDING,
        FAIL_TYPE,
        FAIL_TRUNCATED
    } fatal_kind_t;

    typedef struct packed {
        logic [7:0]  byte_val;
        logic        in_frame;
        logic        frame_start;
        logic        frame_end;
        logic [3:0]  ftype;
        logic        wide;
        logic [23:0] fnum;
        logic [38:0] ftime;
        logic [31:0] foffs;
        logic        idx_point;
        amrsp_pkg::parse_status_t status;
    } parsed_byte_t;

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         cfg_wr_en;
    logic         cfg_wr_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;     // byte_in
    logic         s_tlast;     // end_of_stream
    logic         m_tvalid;
    logic         m_tready;
    // byte_out, frame_start, frame_type, wide_stream, frame_number, frame_time_us,
    // frame_offset, index_point, status, zero fill
    logic [119:0] m_tdata;
    logic         m_tlast;     // frame_end
    logic         m_tuser;     // in_frame

    // parser state as the bench tracks it
    amrsp_pkg::phase_t        stage;
    logic [3:0]               magic_idx;
    logic                     wide_latched;
    logic [5:0]               payload_left;
    logic [3:0]               cur_type;
    logic [23:0]              frames_seen;
    logic [38:0]              stamp_us;
    logic [31:0]              next_offset;
    logic [31:0]              header_at;
    amrsp_pkg::parse_status_t err_code;
    logic                     pad_check_en;

    parsed_byte_t expected_bytes [$];
    parsed_byte_t want_byte;
    parsed_byte_t seen_byte;
    int unsigned  mismatches = 0;
    int unsigned  items_sent = 0;
    int unsigned  idle_cycles = 0;
    int           burst_left = 0;
    bit           hold_req = 1'b0;

    amr_storage_frame_parser i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic frame_type_legal(input logic wide, input logic [3:0] ft);
        if (wide) return !(ft >= 4'd10 && ft <= 4'd13);
        return !(ft >= 4'd12 && ft <= 4'd14);
    endfunction

    function automatic int unsigned frame_payload_bytes(input logic wide, input logic [3:0] ft);
        return wide ? (WB_PAYLOAD_BITS[ft] + 7) / 8 : (NB_PAYLOAD_BITS[ft] + 7) / 8;
    endfunction

    function automatic void clear_parse_state();
        stage        = amrsp_pkg::PH_MAGIC;
        magic_idx    = '0;
        wide_latched = 1'b0;
        payload_left = '0;
        cur_type     = '0;
        frames_seen  = '0;
        stamp_us     = '0;
        next_offset  = '0;
        header_at    = '0;
        err_code     = amrsp_pkg::ST_OK;
    endfunction

    // advances the tracked state by one byte and returns the result the parser owes
    function automatic parsed_byte_t parse_byte(input logic [7:0] b, input logic last);
        parsed_byte_t r;
        logic         done;
        logic         bad;
        logic         err;
        logic         clean;
        logic [3:0]   ft;
        r = '0;
        r.byte_val = b;
        done = 1'b0;
        bad = 1'b0;
        err = 1'b0;
        clean = 1'b0;
        if (stage == amrsp_pkg::PH_HALT) begin
            r.status = amrsp_pkg::ST_HALTED;
        end else if (stage == amrsp_pkg::PH_MAGIC) begin
            // narrowband line ends early with a line feed where wideband has '-'
            if (magic_idx == 4'd5 && b == amrsp_pkg::CHAR_LF) begin
                wide_latched = 1'b0;
                done = 1'b1;
            end else if (magic_idx < 4'd9 && b == WB_MAGIC[magic_idx]) begin
                if (magic_idx == 4'd8) begin
                    wide_latched = 1'b1;
                    done = 1'b1;
                end else begin
                    magic_idx = magic_idx + 4'd1;
                end
            end else begin
                bad = 1'b1;
            end
            if (bad || (last && !done)) begin
                err_code = amrsp_pkg::ST_BAD_MAGIC;
                stage = amrsp_pkg::PH_HALT;
                r.status = amrsp_pkg::ST_BAD_MAGIC;
            end else if (done) begin
                magic_idx = '0;
                stage = amrsp_pkg::PH_HEADER;
                clean = last;
            end
        end else begin
            if (stage == amrsp_pkg::PH_HEADER) begin
                ft = b[6:3];
                if (pad_check_en && (b & amrsp_pkg::PAD_MASK) != 8'h00) begin
                    err_code = amrsp_pkg::ST_PAD_SET;
                    err = 1'b1;
                end else if (!frame_type_legal(wide_latched, ft)) begin
                    err_code = amrsp_pkg::ST_BAD_TYPE;
                    err = 1'b1;
                end else begin
                    cur_type = ft;
                    header_at = next_offset;
                    payload_left = 6'(frame_payload_bytes(wide_latched, ft));
                    r.frame_start = 1'b1;
                    r.idx_point = (frames_seen % IDX_SPACING == 0) &&
                                  (frames_seen / IDX_SPACING < IDX_ENTRIES);
                    if (payload_left == 0) begin
                        r.frame_end = 1'b1;
                    end else if (last) begin
                        err_code = amrsp_pkg::ST_TRUNCATED;
                        err = 1'b1;
                    end else begin
                        stage = amrsp_pkg::PH_PAYLOAD;
                    end
                end
            end else begin
                if (payload_left <= 6'd1) begin
                    payload_left = '0;
                    r.frame_end = 1'b1;
                end else if (last) begin
                    err_code = amrsp_pkg::ST_TRUNCATED;
                    err = 1'b1;
                end else begin
                    payload_left = payload_left - 6'd1;
                end
            end
            if (err) begin
                stage = amrsp_pkg::PH_HALT;
                r = '0;
                r.byte_val = b;
                r.status = err_code;
            end else begin
                r.in_frame = 1'b1;
                r.ftype = cur_type;
                r.fnum = frames_seen;
                r.ftime = stamp_us;
                r.foffs = header_at;
                if (next_offset != amrsp_pkg::OFFSET_MAX) next_offset = next_offset + 32'd1;
                if (r.frame_end) begin
                    if (frames_seen != amrsp_pkg::COUNT_MAX) begin
                        frames_seen = frames_seen + 24'd1;
                        stamp_us = stamp_us + amrsp_pkg::FRAME_US;
                    end
                    stage = amrsp_pkg::PH_HEADER;
                end
                clean = last;
            end
        end
        r.wide = wide_latched;
        if (clean) clear_parse_state();
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_byte.byte_val    = m_tdata[7:0];
            seen_byte.frame_start = m_tdata[8];
            seen_byte.ftype       = m_tdata[12:9];
            seen_byte.wide        = m_tdata[13];
            seen_byte.fnum        = m_tdata[37:14];
            seen_byte.ftime       = m_tdata[76:38];
            seen_byte.foffs       = m_tdata[108:77];
            seen_byte.idx_point   = m_tdata[109];
            seen_byte.status      = amrsp_pkg::parse_status_t'(m_tdata[112:110]);
            seen_byte.frame_end   = m_tlast;
            seen_byte.in_frame    = m_tuser;
            if (expected_bytes.size() == 0) begin
                $error("result transfer with no byte outstanding: data 0x%0h", m_tdata);
                mismatches++;
            end else begin
                want_byte = expected_bytes.pop_front();
                check_field("byte_out", want_byte.byte_val, seen_byte.byte_val);
                check_field("in_frame", want_byte.in_frame, seen_byte.in_frame);
                check_field("frame_start", want_byte.frame_start, seen_byte.frame_start);
                check_field("frame_end", want_byte.frame_end, seen_byte.frame_end);
                check_field("frame_type", want_byte.ftype, seen_byte.ftype);
                check_field("wide_stream", want_byte.wide, seen_byte.wide);
                check_field("frame_number", want_byte.fnum, seen_byte.fnum);
                check_field("frame_time_us", want_byte.ftime, seen_byte.ftime);
                check_field("frame_offset", want_byte.foffs, seen_byte.foffs);
                check_field("index_point", want_byte.idx_point, seen_byte.idx_point);
                check_field("status", want_byte.status, seen_byte.status);
                check_field("zero_fill", '0, m_tdata[119:113]);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("amr_storage_frame_parser: mismatch");
            $finish;
        end
    end

    // receiver: segments that are always ready, ready with regular gaps, or randomly ready; held off on hold_req
    initial begin
        int unsigned seg_left;
        int unsigned seg_mode;
        int unsigned slot;
        seg_left = 0;
        seg_mode = 0;
        slot = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 150);
                    seg_mode = $urandom_range(0, 2);
                end
                seg_left--;
                slot++;
                case (seg_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= (slot % 4 != 0);
                    default: m_tready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_bytes.push_back(parse_byte(b, last));
        items_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_pad_check(input logic v);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pad_check_en = v;
    endtask

    task automatic send_magic(input logic wide, input logic last_byte);
        if (wide) begin
            for (int i = 0; i < 9; i++) send_byte(WB_MAGIC[i], last_byte && i == 8);
        end else begin
            for (int i = 0; i < 5; i++) send_byte(WB_MAGIC[i], 1'b0);
            send_byte(amrsp_pkg::CHAR_LF, last_byte);
        end
    endtask

    // header: padding bit 7, type in bits 6..3, quality bit 2, padding bits 1..0
    task automatic send_frame(input logic wide, input logic [3:0] ft, input logic [2:0] pad,
                              input logic last_frame);
        int unsigned n;
        n = frame_payload_bytes(wide, ft);
        send_byte({pad[2], ft, 1'($urandom_range(0, 1)), pad[1:0]}, last_frame && n == 0);
        for (int k = 0; k < n; k++) send_byte(8'($urandom), last_frame && k == n - 1);
    endtask

    task automatic send_random_file();
        logic        wide;
        int unsigned frames;
        logic [3:0]  ft;
        logic [2:0]  pad;
        wide = 1'($urandom_range(0, 1));
        frames = $urandom_range(0, 6);
        send_magic(wide, frames == 0);
        for (int i = 0; i < frames; i++) begin
            // lean towards the short frame types so more headers pass per byte
            do begin
                ft = 4'($urandom_range(0, 15));
            end while (!frame_type_legal(wide, ft) ||
                       (frame_payload_bytes(wide, ft) > 20 && $urandom_range(0, 2) != 0));
            pad = pad_check_en ? 3'b000 : 3'($urandom_range(0, 7));
            send_frame(wide, ft, pad, i == frames - 1);
        end
    endtask

    // empty narrowband file, then a wideband file with no-data frames and payload extremes
    task automatic test_directed_files();
        send_magic(1'b0, 1'b1);
        send_magic(1'b1, 1'b0);
        send_byte(8'h78, 1'b0);
        send_byte(8'h70, 1'b0);
        send_byte(8'h48, 1'b0);
        send_byte(8'hff, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    // padding bits set in every header are let through once the check is off
    task automatic test_padding_unchecked();
        logic       wide;
        logic [3:0] ft;
        set_pad_check(1'b0);
        wide = 1'($urandom_range(0, 1));
        send_magic(wide, 1'b0);
        for (int i = 0; i < 8; i++) begin
            do ft = 4'($urandom_range(0, 15)); while (!frame_type_legal(wide, ft));
            send_frame(wide, ft, (i == 0) ? 3'b111 : 3'($urandom_range(1, 7)), i == 7);
        end
        set_pad_check(1'b1);
    endtask

    // receiver holds off while the sender keeps offering, so the input side stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        send_magic(1'b1, 1'b0);
        for (int i = 0; i < 6; i++) send_frame(1'b1, 4'd9, 3'b000, i == 5);
    endtask

    // one long file of mostly one-byte frames that passes several index points
    task automatic test_index_table();
        logic       wide;
        logic [3:0] ft;
        int unsigned frames;
        wide = 1'($urandom_range(0, 1));
        frames = IDX_SPACING * 8 + 20;
        send_magic(wide, 1'b0);
        for (int i = 0; i < frames; i++) begin
            if ($urandom_range(0, 15) == 0) ft = wide ? 4'd9 : 4'd11;
            else ft = wide ? 4'($urandom_range(14, 15)) : 4'd15;
            send_frame(wide, ft, 3'b000, i == frames - 1);
        end
    endtask

    task automatic test_random_files();
        int unsigned first;
        int unsigned files;
        first = items_sent;
        files = 0;
        while (items_sent - first < RANDOM_BYTES) begin
            send_random_file();
            files++;
            if (files % 5 == 0) set_pad_check(1'($urandom_range(0, 1)));
        end
    endtask

    // one error per run since only reset clears a halt; the seed picks which one
    task automatic test_fatal_error();
        fatal_kind_t kind;
        int unsigned pos;
        logic [7:0]  b;
        logic        wide;
        set_pad_check(1'b1);
        kind = fatal_kind_t'($urandom_range(0, 4));
        wide = 1'($urandom_range(0, 1));
        case (kind)
            FAIL_MAGIC_BYTE: begin
                pos = $urandom_range(0, 8);
                for (int i = 0; i < pos; i++) send_byte(WB_MAGIC[i], 1'b0);
                do b = 8'($urandom);
                while (b == WB_MAGIC[pos] || (pos == 5 && b == amrsp_pkg::CHAR_LF));
                send_byte(b, 1'($urandom_range(0, 1)));
            end
            FAIL_MAGIC_CUT: begin
                pos = $urandom_range(0, 7);
                for (int i = 0; i <= pos; i++) send_byte(WB_MAGIC[i], i == pos);
            end
            FAIL_PADDING: begin
                send_magic(wide, 1'b0);
                send_frame(wide, 4'd15, 3'b000, 1'b0);
                send_byte({1'($urandom_range(0, 1)), 4'd15, 1'b1,
                           2'($urandom_range(1, 3))}, 1'b0);
            end
            FAIL_TYPE: begin
                send_magic(wide, 1'b0);
                send_byte({1'b0, 4'(wide ? $urandom_range(10, 13) : $urandom_range(12, 14)),
                           1'b1, 2'b00}, 1'b0);
            end
            default: begin
                send_magic(wide, 1'b0);
                if ($urandom_range(0, 1)) begin
                    send_byte({1'b0, 4'd0, 1'b1, 2'b00}, 1'b1);
                end else begin
                    send_byte({1'b0, 4'd0, 1'b1, 2'b00}, 1'b0);
                    pos = $urandom_range(1, frame_payload_bytes(wide, 4'd0) - 1);
                    for (int i = 0; i < pos; i++) send_byte(8'($urandom), i == pos - 1);
                end
            end
        endcase
        for (int i = 0; i < 30; i++) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        pad_check_en = 1'b1;
        clear_parse_state();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_files();
        test_padding_unchecked();
        test_backpressure();
        test_index_table();
        test_random_files();
        test_fatal_error();

        drain_results();
        repeat (4) @(posedge aclk);
        if (mismatches == 0) begin
            $display("amr_storage_frame_parser: match");
        end else begin
            $display("amr_storage_frame_parser: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/amrsp_pkg.sv
design/amrsp_hdr_decode.sv
design/amr_storage_frame_parser.sv
bench/amr_storage_frame_parser_test.sv
